[src/pirr_pkg.sv]
// ---------------------------------------------------------------------------
// pirr_pkg
// Shared widths, constants, item type and arctangent table for the
// point in rotated rectangle unit.
// ---------------------------------------------------------------------------
package pirr_pkg;

   // default and maximum number of cordic rotation cells
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_STAGES_MAX = 24;

   // datapath widths
   localparam int XY_W    = 34;   // cordic x and y, Q2.30 with headroom
   localparam int Z_W     = 32;   // cordic angle accumulator, Q.28
   localparam int PROD_W  = 66;   // extent times cos or sin
   localparam int SUM_W   = 68;   // corner offset before rounding
   localparam int COORD_W = 38;   // corner coordinates, Q16.16
   localparam int VEC_W   = 39;   // edge vectors and point offsets
   localparam int LO_W    = 20;   // low part of a split operand
   localparam int HI_W    = VEC_W - LO_W;
   localparam int DOT_W   = 80;   // full width dot product

   // cordic start value and fold limits for the Q3.13 angle
   localparam logic signed [XY_W-1:0] CORDIC_X0   = 34'sd652032874;
   localparam logic signed [16:0]     PI_Q13      = 17'sd25736;
   localparam logic signed [16:0]     HALF_PI_Q13 = 17'sd12868;

   // one query as it travels down the pipeline
   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        half_width;
      logic [30:0]        half_length;
      logic               flip;
   } item_type;

   // atan(2^-idx) in Q.28
   function automatic logic signed [Z_W-1:0] atan_q28(input int idx);
      logic signed [Z_W-1:0] r;
      unique case (idx)
         0:  r = 32'sd210828714;
         1:  r = 32'sd124459457;
         2:  r = 32'sd65760959;
         3:  r = 32'sd33381290;
         4:  r = 32'sd16755422;
         5:  r = 32'sd8385879;
         6:  r = 32'sd4193963;
         7:  r = 32'sd2097109;
         8:  r = 32'sd1048571;
         9:  r = 32'sd524287;
         10: r = 32'sd262144;
         11: r = 32'sd131072;
         12: r = 32'sd65536;
         13: r = 32'sd32768;
         14: r = 32'sd16384;
         15: r = 32'sd8192;
         16: r = 32'sd4096;
         17: r = 32'sd2048;
         18: r = 32'sd1024;
         19: r = 32'sd512;
         20: r = 32'sd256;
         21: r = 32'sd128;
         22: r = 32'sd64;
         23: r = 32'sd32;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[src/pirr_cordic_cell.sv]
// ---------------------------------------------------------------------------
// pirr_cordic_cell
// One rotation-mode cordic cell: a fixed shift, a fixed arctangent step and
// a register that hands x, y, z and the query on to the next cell.
// ---------------------------------------------------------------------------
module pirr_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  pirr_pkg::item_type                in_item,
   input  logic signed [pirr_pkg::XY_W-1:0]  in_x,
   input  logic signed [pirr_pkg::XY_W-1:0]  in_y,
   input  logic signed [pirr_pkg::Z_W-1:0]   in_z,
   output logic                              out_valid,
   output pirr_pkg::item_type                out_item,
   output logic signed [pirr_pkg::XY_W-1:0]  out_x,
   output logic signed [pirr_pkg::XY_W-1:0]  out_y,
   output logic signed [pirr_pkg::Z_W-1:0]   out_z
);
   import pirr_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q28(STAGE);

   logic                   valid_ff;
   item_type               item_ff;
   logic signed [XY_W-1:0] x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [Z_W-1:0]  z_ff, z_in;

   // micro-rotation, direction from the sign of the residual angle
   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (!in_z[Z_W-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN_STEP;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN_STEP;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= in_item;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

[src/pirr_geom.sv]
// ---------------------------------------------------------------------------
// pirr_geom
// Corner construction and edge tests: cos and sin sign fix, extent products,
// rounded corners, edge vectors, split dot products and the final compares.
// ---------------------------------------------------------------------------
module pirr_geom (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  pirr_pkg::item_type                in_item,
   input  logic signed [pirr_pkg::XY_W-1:0]  in_x,
   input  logic signed [pirr_pkg::XY_W-1:0]  in_y,
   output logic                              res_valid,
   output logic                              res_inside
);
   import pirr_pkg::*;

   localparam int NSTG = 8;
   localparam int NMUL = 8;
   localparam logic signed [SUM_W-1:0] RND = SUM_W'(64'sd536870912);

   logic [NSTG-1:0] valid_ff, valid_in;

   // rounded corner: center + ((+-p +-q + 2^29) >>> 30)
   function automatic logic signed [COORD_W-1:0] corner(
      input logic signed [31:0]       cen,
      input logic signed [PROD_W-1:0] p,
      input logic signed [PROD_W-1:0] q,
      input logic                     neg_p,
      input logic                     neg_q);
      logic signed [SUM_W-1:0] sp, sq, sum, sh;
      sp  = neg_p ? -SUM_W'(p) : SUM_W'(p);
      sq  = neg_q ? -SUM_W'(q) : SUM_W'(q);
      sum = sp + sq + RND;
      sh  = sum >>> 30;
      return COORD_W'(cen) + COORD_W'(sh);
   endfunction

   // stage 0: sign fix of cos and sin
   item_type               item0_ff;
   logic signed [XY_W-1:0] c_ff, s_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         item0_ff <= in_item;
         c_ff     <= in_item.flip ? -in_x : in_x;
         s_ff     <= in_item.flip ? -in_y : in_y;
      end
   end

   // stage 1: extent products
   item_type                 item1_ff;
   logic signed [31:0]       w_s, l_s;
   logic signed [PROD_W-1:0] wc_ff, ws_ff, lc_ff, ls_ff;
   assign w_s = $signed({1'b0, item0_ff.half_width});
   assign l_s = $signed({1'b0, item0_ff.half_length});
   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff <= item0_ff;
         wc_ff    <= w_s * c_ff;
         ws_ff    <= w_s * s_ff;
         lc_ff    <= l_s * c_ff;
         ls_ff    <= l_s * s_ff;
      end
   end

   // stage 2: corners a, b and c
   logic signed [31:0]        px2_ff, py2_ff;
   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, qx_ff, qy_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         px2_ff <= item1_ff.point_x;
         py2_ff <= item1_ff.point_y;
         ax_ff  <= corner(item1_ff.center_x, wc_ff, ls_ff, 1'b1, 1'b1);
         ay_ff  <= corner(item1_ff.center_y, ws_ff, lc_ff, 1'b1, 1'b0);
         bx_ff  <= corner(item1_ff.center_x, wc_ff, ls_ff, 1'b0, 1'b1);
         by_ff  <= corner(item1_ff.center_y, ws_ff, lc_ff, 1'b0, 1'b0);
         qx_ff  <= corner(item1_ff.center_x, wc_ff, ls_ff, 1'b0, 1'b0);
         qy_ff  <= corner(item1_ff.center_y, ws_ff, lc_ff, 1'b0, 1'b1);
      end
   end

   // stage 3: edge vectors and point offsets
   logic signed [VEC_W-1:0] abx_ff, aby_ff, bcx_ff, bcy_ff;
   logic signed [VEC_W-1:0] apx_ff, apy_ff, bpx_ff, bpy_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         abx_ff <= VEC_W'(bx_ff) - VEC_W'(ax_ff);
         aby_ff <= VEC_W'(by_ff) - VEC_W'(ay_ff);
         bcx_ff <= VEC_W'(qx_ff) - VEC_W'(bx_ff);
         bcy_ff <= VEC_W'(qy_ff) - VEC_W'(by_ff);
         apx_ff <= VEC_W'(px2_ff) - VEC_W'(ax_ff);
         apy_ff <= VEC_W'(py2_ff) - VEC_W'(ay_ff);
         bpx_ff <= VEC_W'(px2_ff) - VEC_W'(bx_ff);
         bpy_ff <= VEC_W'(py2_ff) - VEC_W'(by_ff);
      end
   end

   // operand pairs of the eight products
   logic signed [VEC_W-1:0] opa [NMUL];
   logic signed [VEC_W-1:0] opb [NMUL];
   always_comb begin
      opa[0] = abx_ff; opb[0] = apx_ff;
      opa[1] = aby_ff; opb[1] = apy_ff;
      opa[2] = abx_ff; opb[2] = abx_ff;
      opa[3] = aby_ff; opb[3] = aby_ff;
      opa[4] = bcx_ff; opb[4] = bpx_ff;
      opa[5] = bcy_ff; opb[5] = bpy_ff;
      opa[6] = bcx_ff; opb[6] = bcx_ff;
      opa[7] = bcy_ff; opb[7] = bcy_ff;
   end

   // stage 4: partial products on split operands
   logic signed [2*HI_W-1:0]      pp_hh_ff [NMUL];
   logic signed [HI_W+LO_W:0]     pp_hl_ff [NMUL];
   logic signed [HI_W+LO_W:0]     pp_lh_ff [NMUL];
   logic signed [2*LO_W+1:0]      pp_ll_ff [NMUL];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NMUL; k++) begin
            pp_hh_ff[k] <= $signed(opa[k][VEC_W-1:LO_W]) * $signed(opb[k][VEC_W-1:LO_W]);
            pp_hl_ff[k] <= $signed(opa[k][VEC_W-1:LO_W]) * $signed({1'b0, opb[k][LO_W-1:0]});
            pp_lh_ff[k] <= $signed({1'b0, opa[k][LO_W-1:0]}) * $signed(opb[k][VEC_W-1:LO_W]);
            pp_ll_ff[k] <= $signed({1'b0, opa[k][LO_W-1:0]})
                         * $signed({1'b0, opb[k][LO_W-1:0]});
         end
      end
   end

   // stage 5: recombine partial products
   logic signed [DOT_W-1:0] prod_ff [NMUL];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NMUL; k++) begin
            prod_ff[k] <= (DOT_W'(pp_hh_ff[k]) <<< (2*LO_W))
                        + ((DOT_W'(pp_hl_ff[k]) + DOT_W'(pp_lh_ff[k])) <<< LO_W)
                        + DOT_W'(pp_ll_ff[k]);
         end
      end
   end

   // stage 6: dot products
   logic signed [DOT_W-1:0] dot_ff [4];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            dot_ff[k] <= prod_ff[2*k] + prod_ff[2*k+1];
         end
      end
   end

   // stage 7: projection range tests, boundaries inclusive
   logic inside_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         inside_ff <= !dot_ff[0][DOT_W-1] && (dot_ff[0] <= dot_ff[1])
                   && !dot_ff[2][DOT_W-1] && (dot_ff[2] <= dot_ff[3]);
      end
   end

   // valid flags shift along with the data
   assign valid_in = {valid_ff[NSTG-2:0], in_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   assign res_valid  = valid_ff[NSTG-1];
   assign res_inside = inside_ff;

endmodule

[src/point_in_rotated_rectangle_unit.sv]
// ---------------------------------------------------------------------------
// point_in_rotated_rectangle_unit
// Tests whether a query point lies inside or on a rotated rectangle.
//
// Input channel req_*: point, rectangle center, half extents and angle,
// transferred when req_valid and req_ready are both high. Result channel
// rsp_*: one inside flag per query, in query order.
// The datapath is a pipeline: an angle fold register, CORDIC_STAGES cordic
// cells (at most CORDIC_STAGES_MAX), eight geometry stages and an output
// register. One query is taken every cycle while req_ready is high; the
// rate is set by the cell chain, which moves one position per cycle.
// A two-entry output (result register plus skid register) lets the
// pipeline keep moving after rsp_ready drops until a result must enter the
// skid register; while it holds a result the whole pipeline and req_ready
// stall. Synchronous reset clears all valid flags, not the data registers.
// ---------------------------------------------------------------------------
module point_in_rotated_rectangle_unit
   import pirr_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_half_width,
   input  logic [30:0]        req_half_length,
   input  logic signed [15:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_inside_res
);

   localparam int NCELL = (CORDIC_STAGES < CORDIC_STAGES_MAX) ?
                          CORDIC_STAGES : CORDIC_STAGES_MAX;

   logic en;

   // angle fold into minus pi/2 .. pi/2
   logic signed [16:0]    ang_ext, ang_fold;
   logic                  flip;
   logic signed [Z_W-1:0] z_start;
   always_comb begin
      ang_ext = 17'(req_angle);
      flip    = 1'b0;
      ang_fold = ang_ext;
      if (ang_ext > HALF_PI_Q13) begin
         ang_fold = ang_ext - PI_Q13;
         flip     = 1'b1;
      end else if (ang_ext < -HALF_PI_Q13) begin
         ang_fold = ang_ext + PI_Q13;
         flip     = 1'b1;
      end
      z_start = Z_W'(ang_fold) <<< 15;
   end

   // input register
   logic                  v0_ff;
   item_type              item0_ff;
   logic signed [Z_W-1:0] z0_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         item0_ff.point_x     <= req_point_x;
         item0_ff.point_y     <= req_point_y;
         item0_ff.center_x    <= req_center_x;
         item0_ff.center_y    <= req_center_y;
         item0_ff.half_width  <= req_half_width;
         item0_ff.half_length <= req_half_length;
         item0_ff.flip        <= flip;
         z0_ff                <= z_start;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   // cordic cell chain
   logic                   cv [NCELL+1];
   item_type               ci [NCELL+1];
   logic signed [XY_W-1:0] cx [NCELL+1];
   logic signed [XY_W-1:0] cy [NCELL+1];
   logic signed [Z_W-1:0]  cz [NCELL+1];

   assign cv[0] = v0_ff;
   assign ci[0] = item0_ff;
   assign cx[0] = CORDIC_X0;
   assign cy[0] = '0;
   assign cz[0] = z0_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      pirr_cordic_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv[g]),
         .in_item   (ci[g]),
         .in_x      (cx[g]),
         .in_y      (cy[g]),
         .in_z      (cz[g]),
         .out_valid (cv[g+1]),
         .out_item  (ci[g+1]),
         .out_x     (cx[g+1]),
         .out_y     (cy[g+1]),
         .out_z     (cz[g+1])
      );
   end

   // corner construction and edge tests
   logic res_valid, res_inside;
   pirr_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (cv[NCELL]),
      .in_item    (ci[NCELL]),
      .in_x       (cx[NCELL]),
      .in_y       (cy[NCELL]),
      .res_valid  (res_valid),
      .res_inside (res_inside)
   );

   // output register with skid entry
   logic rsp_valid_ff, rsp_valid_in, rsp_inside_ff, rsp_inside_in;
   logic sk_valid_ff, sk_valid_in, sk_inside_ff, sk_inside_in;
   logic out_free;

   assign en       = !sk_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      sk_valid_in   = sk_valid_ff;
      sk_inside_in  = sk_inside_ff;
      if (out_free) begin
         if (sk_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_inside_in = sk_inside_ff;
            sk_valid_in   = 1'b0;
         end else if (res_valid) begin
            rsp_valid_in  = 1'b1;
            rsp_inside_in = res_inside;
         end else begin
            rsp_valid_in  = 1'b0;
         end
      end else if (en && res_valid) begin
         sk_valid_in  = 1'b1;
         sk_inside_in = res_inside;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sk_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sk_valid_ff  <= sk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      sk_inside_ff  <= sk_inside_in;
   end

   assign req_ready      = en;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // the skid entry is only ever occupied behind a full output register
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      sk_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   // the skid entry only fills when the output was stalled
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(sk_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid entry filled without a stalled output");

   // a drained skid entry always lands in the output register
   a_skid_drain : assert property (@(posedge clock) disable iff (reset)
      (sk_valid_ff && rsp_ready) |=> (rsp_valid_ff && !sk_valid_ff))
      else $error("skid entry lost on drain");

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// point in rotated rectangle unit testbench
// Sends query points and rectangles through the req channel and checks
// each inside flag from the rsp channel against a local model of the
// cordic, the corner rotation and the dot product tests, or against the
// table's own flag where a directed row gives one. A directed table runs
// first, then random queries, with bursty sending and a stalling receiver.
// ---------------------------------------------------------------------------
module testbench;
   import pirr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM  = 1625;
   localparam int LIMIT     = 400000;
   localparam int DRAIN_CYC = CORDIC_STAGES_DEF + 30;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        hw;
      logic [30:0]        hl;
      logic signed [15:0] ang;
      bit                 known;
      bit                 flag;
   } query_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic signed [31:0] req_center_x;
   logic signed [31:0] req_center_y;
   logic [30:0]        req_half_width;
   logic [30:0]        req_half_length;
   logic signed [15:0] req_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_inside_res;

   bit     inside_queue[$];
   int     errors;
   int     cycles;
   int     n_sent;
   int     n_inside;
   int     n_outside;
   bit     typed_flag;
   bit     typed_valid;
   logic [15:0] stall_pattern;

   point_in_rotated_rectangle_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_half_width (req_half_width),
      .req_half_length(req_half_length),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_inside_res (rsp_inside_res)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // offset back to Q16.16, round half up
   function automatic longint round_q30(longint p, longint q);
      return (p - q + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic signed [127:0] dot2(longint ux, longint uy,
                                                longint vx, longint vy);
      logic signed [127:0] a, b, c, d;
      a = ux; b = uy; c = vx; d = vy;
      return a * c + b * d;
   endfunction

   // expected inside flag for one query
   function automatic bit inside_of(query_type q);
      longint x, y, z, dx, dy, c, s, w, l, a;
      longint ax, ay, bx, by, qx, qy;
      logic signed [127:0] d1, d2, d3, d4;
      bit flip;
      x = 652032874; y = 0; flip = 0;
      a = q.ang;
      if (a > 12868) begin
         a = a - 25736; flip = 1;
      end else if (a < -12868) begin
         a = a + 25736; flip = 1;
      end
      z = a * 32768;
      for (int i = 0; i < CORDIC_STAGES_DEF && i < CORDIC_STAGES_MAX; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(atan_q28(i));
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(atan_q28(i));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      w = longint'(q.hw);
      l = longint'(q.hl);
      ax = longint'(q.cx) + round_q30(-w * c, l * s);
      ay = longint'(q.cy) + round_q30(-w * s, -l * c);
      bx = longint'(q.cx) + round_q30(w * c, l * s);
      by = longint'(q.cy) + round_q30(w * s, -l * c);
      qx = longint'(q.cx) + round_q30(w * c, -l * s);
      qy = longint'(q.cy) + round_q30(w * s, l * c);
      d1 = dot2(bx - ax, by - ay, longint'(q.px) - ax, longint'(q.py) - ay);
      d2 = dot2(bx - ax, by - ay, bx - ax, by - ay);
      d3 = dot2(qx - bx, qy - by, longint'(q.px) - bx, longint'(q.py) - by);
      d4 = dot2(qx - bx, qy - by, qx - bx, qy - by);
      return (d1 >= 0) && (d1 <= d2) && (d3 >= 0) && (d3 <= d4);
   endfunction

   function automatic query_type mk(int px, int py, int cx, int cy, int hw, int hl,
                                    int ang, bit known, bit flag);
      query_type q;
      q.px = px; q.py = py; q.cx = cx; q.cy = cy;
      q.hw = hw[30:0]; q.hl = hl[30:0]; q.ang = ang[15:0];
      q.known = known; q.flag = flag;
      return q;
   endfunction

   // random query, mostly near a modest rectangle
   function automatic query_type rand_query();
      query_type q;
      int        sel, span;
      sel = $urandom_range(0, 99);
      q.known = 0; q.flag = 0;
      q.ang = 16'($urandom());
      if (sel < 15) begin
         q.px = $urandom(); q.py = $urandom();
         q.cx = $urandom(); q.cy = $urandom();
         q.hw = 31'($urandom()); q.hl = 31'($urandom());
      end else begin
         q.cx = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
         q.cy = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
         q.hw = (sel < 20) ? 31'd0 : 31'($urandom_range(0, 32'h003f_ffff));
         q.hl = (sel > 95) ? 31'd0 : 31'($urandom_range(0, 32'h003f_ffff));
         span = int'(q.hw > q.hl ? q.hw : q.hl) + 1;
         span = span + span / 2;
         q.px = q.cx + $signed($urandom_range(0, 2 * span)) - span;
         q.py = q.cy + $signed($urandom_range(0, 2 * span)) - span;
         // edge midpoint on an unrotated rectangle
         if (sel < 28) begin
            q.ang = 0;
            q.px = q.cx + int'(q.hw);
            q.py = q.cy;
         end
      end
      return q;
   endfunction

   // receiver stall pattern: either always ready or a random mask
   always @(negedge clock) begin
      if (cycles % 64 == 0)
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom());
      rsp_ready <= reset ? 1'b0 : stall_pattern[cycles % 16];
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // predict at each input transfer
   always @(posedge clock) begin
      query_type q;
      bit        p;
      if (!reset && req_valid && req_ready) begin
         q = mk(req_point_x, req_point_y, req_center_x, req_center_y,
                int'(req_half_width), int'(req_half_length), int'(req_angle), 0, 0);
         p = inside_of(q);
         if (typed_valid && typed_flag != p)
            $display("%0t: table row disagrees with model: row %0b model %0b",
                     $time, typed_flag, p);
         inside_queue.push_back(typed_valid ? typed_flag : p);
      end
   end

   // check each result transfer
   always @(posedge clock) begin
      bit e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inside_queue.size() == 0) begin
            $display("%0t: unexpected result %0b", $time, rsp_inside_res);
            errors <= errors + 1;
         end else begin
            e = inside_queue.pop_front();
            if (e) n_inside <= n_inside + 1;
            else n_outside <= n_outside + 1;
            if (rsp_inside_res !== e) begin
               $display("%0t: inside_res expected %0b actual %0b",
                        $time, e, rsp_inside_res);
               errors <= errors + 1;
            end
         end
      end
   end

   task automatic send(query_type q);
      req_valid       <= 1'b1;
      req_point_x     <= q.px;
      req_point_y     <= q.py;
      req_center_x    <= q.cx;
      req_center_y    <= q.cy;
      req_half_width  <= q.hw;
      req_half_length <= q.hl;
      req_angle       <= q.ang;
      typed_valid     <= q.known;
      typed_flag      <= q.flag;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      n_sent++;
   endtask

   query_type directed[$];
   int        burst;

   initial begin
      errors = 0; cycles = 0; n_sent = 0; n_inside = 0; n_outside = 0;
      stall_pattern = 16'hffff;
      reset = 1'b1; req_valid = 1'b0; rsp_ready = 1'b0;
      typed_valid = 0; typed_flag = 0;
      req_point_x = 0; req_point_y = 0; req_center_x = 0; req_center_y = 0;
      req_half_width = 0; req_half_length = 0; req_angle = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // both extents zero: every point is inside
      directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 1));
      directed.push_back(mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 1, 1));
      directed.push_back(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                            0, 0, 32'hffff8000, 1, 1));
      // point at center of a unit square, and one far outside it
      directed.push_back(mk(0, 0, 0, 0, 32'h10000, 32'h10000, 0, 1, 1));
      directed.push_back(mk(32'h640000, 0, 0, 0, 32'h10000, 32'h10000, 0, 1, 0));
      // angle fold limits and out-of-range angles
      directed.push_back(mk(32'h8000, 32'h18000, 0, 0, 32'h10000, 32'h20000, 12868, 0, 0));
      directed.push_back(mk(32'h8000, 32'h18000, 0, 0, 32'h10000, 32'h20000, 12869, 0, 0));
      directed.push_back(mk(32'h8000, 32'h18000, 0, 0, 32'h10000, 32'h20000, -12868, 0, 0));
      directed.push_back(mk(32'h8000, 32'h18000, 0, 0, 32'h10000, 32'h20000, -12869, 0, 0));
      directed.push_back(mk(32'h18000, 32'h8000, 0, 0, 32'h10000, 32'h20000, 25736, 0, 0));
      directed.push_back(mk(32'h18000, 32'h8000, 0, 0, 32'h10000, 32'h20000, -25736, 0, 0));
      directed.push_back(mk(32'h18000, 32'h8000, 0, 0, 32'h10000, 32'h20000, 32767, 0, 0));
      directed.push_back(mk(32'h18000, 32'h8000, 0, 0, 32'h10000, 32'h20000, -32768, 0, 0));
      // boundary on an edge and at a corner, and just past an edge
      directed.push_back(mk(32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0));
      directed.push_back(mk(32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0, 0, 0));
      directed.push_back(mk(32'h10001, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0));
      // largest extents and coordinate extremes, then a zero-width rectangle
      directed.push_back(mk(32'h7fffffff, 32'h7fffffff, 0, 0,
                            32'h7fffffff, 32'h7fffffff, 0, 0, 0));
      directed.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 6434, 0, 0));
      directed.push_back(mk(0, 0, 32'h80000000, 32'h80000000,
                            32'h7fffffff, 0, -6434, 0, 0));
      directed.push_back(mk(0, 32'h40000, 0, 0, 0, 32'h80000, 0, 0, 0));
      directed.push_back(mk(32'h123, 32'h40000, 0, 0, 0, 32'h80000, 0, 0, 0));
      foreach (directed[k]) send(directed[k]);

      // random part: bursts with gaps
      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
            send(rand_query());
            // once, hold off until the pipeline has drained
            if (n == N_RANDOM / 2) begin
               req_valid <= 1'b0;
               while (inside_queue.size() != 0) @(negedge clock);
            end
         end
         req_valid <= 1'b0;
         typed_valid <= 0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clock);
      end
      req_valid <= 1'b0;
      typed_valid <= 0;

      while (inside_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);

      $display("sent %0d queries: %0d inside, %0d outside, in %0d cycles",
               n_sent, n_inside, n_outside, cycles);
      $display("directed angle folds, zero and full extents, boundaries; random near and wide");
      if (errors == 0 && inside_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[point_in_rotated_rectangle_unit.f]
src/pirr_pkg.sv
src/pirr_cordic_cell.sv
src/pirr_geom.sv
src/point_in_rotated_rectangle_unit.sv
dv/testbench.sv
